FILE: sv/uf_pkg.sv
// ----------------------------------------------------------------------------
// uf_pkg
// Shared types and constants for the union-find engine: field widths,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package uf_pkg;

  localparam int ELEM_W           = 10;
  localparam int SIZE_W           = 11;
  localparam int DEF_NUM_ELEMENTS = 1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_CHK,
    ST_A_GRD,
    ST_B_CHK,
    ST_B_GRD,
    ST_MERGE,
    ST_EMIT
  } uf_state_t;

  typedef struct packed {
    logic clr_write;  // write one identity entry of the clearing pass
    logic load_in;    // take the request and read parent of elem_a
    logic a_root;     // root of elem_a found, start the walk of elem_b
    logic hop_read;   // read the grandparent
    logic hop_write;  // shorten the link and step to the grandparent
    logic b_root;     // root of elem_b found
    logic merge;      // link root_b under root_a, add the counts
    logic load_out;   // move the result into the output register
  } uf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_root;
    logic merge_needed;
    logic out_free;
  } uf_stat_t;

endpackage

FILE: sv/uf_if.sv
// ----------------------------------------------------------------------------
// uf_req_if / uf_rsp_if
// Valid/ready channels for requests and results of the union-find engine.
// ----------------------------------------------------------------------------
interface uf_req_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [uf_pkg::ELEM_W-1:0] elem_a;
  logic [uf_pkg::ELEM_W-1:0] elem_b;

  modport source (output valid, op, elem_a, elem_b, input ready);
  modport sink   (input valid, op, elem_a, elem_b, output ready);
endinterface

interface uf_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [uf_pkg::ELEM_W-1:0] root_a;
  logic [uf_pkg::ELEM_W-1:0] root_b;
  logic                     same_set;
  logic                     merged;
  logic [uf_pkg::SIZE_W-1:0] set_size;

  modport source (output valid, root_a, root_b, same_set, merged, set_size, input ready);
  modport sink   (input valid, root_a, root_b, same_set, merged, set_size, output ready);
endinterface

FILE: sv/uf_ctrl.sv
// ----------------------------------------------------------------------------
// uf_ctrl
// Controller: sequences the clearing pass, the two root walks with path
// halving, the optional merge and the handoff to the output register.
// ----------------------------------------------------------------------------
module uf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  uf_pkg::uf_stat_t stat,
  output uf_pkg::uf_cmd_t  cmd
);
  import uf_pkg::*;

  uf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (stat.is_root) begin
          cmd.a_root = 1'b1;
          state_next = ST_B_CHK;
        end else begin
          cmd.hop_read = 1'b1;
          state_next   = ST_A_GRD;
        end
      end
      ST_A_GRD: begin
        cmd.hop_write = 1'b1;
        state_next    = ST_A_CHK;
      end
      ST_B_CHK: begin
        if (stat.is_root) begin
          cmd.b_root = 1'b1;
          state_next = stat.merge_needed ? ST_MERGE : ST_EMIT;
        end else begin
          cmd.hop_read = 1'b1;
          state_next   = ST_B_GRD;
        end
      end
      ST_B_GRD: begin
        cmd.hop_write = 1'b1;
        state_next    = ST_B_CHK;
      end
      ST_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

FILE: sv/uf_dp.sv
// ----------------------------------------------------------------------------
// uf_dp
// Datapath: parent and count memories, walk registers, result registers
// and the output register.
// ----------------------------------------------------------------------------
module uf_dp #(
  parameter int NUM_ELEMENTS = uf_pkg::DEF_NUM_ELEMENTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  uf_pkg::uf_cmd_t           cmd,
  output uf_pkg::uf_stat_t          stat,
  input  logic                      req_op,
  input  logic [uf_pkg::ELEM_W-1:0] req_elem_a,
  input  logic [uf_pkg::ELEM_W-1:0] req_elem_b,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic [uf_pkg::ELEM_W-1:0] rsp_root_a,
  output logic [uf_pkg::ELEM_W-1:0] rsp_root_b,
  output logic                      rsp_same_set,
  output logic                      rsp_merged,
  output logic [uf_pkg::SIZE_W-1:0] rsp_set_size
);
  import uf_pkg::*;

  localparam int IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(NUM_ELEMENTS + 1);
  localparam logic [31:0]      MAX_IDX  = 32'(NUM_ELEMENTS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMENTS - 1);

  logic [IDX_W-1:0] parent_mem [NUM_ELEMENTS];
  logic [CNT_W-1:0] count_mem  [NUM_ELEMENTS];

  logic [IDX_W-1:0] clr_cnt;
  logic [IDX_W-1:0] node;
  logic [IDX_W-1:0] b_idx;
  logic             op;
  logic [IDX_W-1:0] ra;
  logic [IDX_W-1:0] rb;
  logic             same;
  logic             joined;
  logic [CNT_W-1:0] size;
  logic [IDX_W-1:0] p_rdata;
  logic [CNT_W-1:0] c_rdata;

  logic [31:0]      a_wide, b_wide, a_clamp, b_clamp;
  logic [IDX_W-1:0] a_idx_in, b_idx_in;
  logic             p_we, p_re, c_we, c_re;
  logic [IDX_W-1:0] p_waddr, p_wdata, p_raddr, c_waddr, c_raddr;
  logic [CNT_W-1:0] c_wdata;
  logic [CNT_W-1:0] sum;
  logic [31:0]      ra_wide, rb_wide, size_wide;

  // indexes past the last element saturate
  assign a_wide   = 32'(req_elem_a);
  assign b_wide   = 32'(req_elem_b);
  assign a_clamp  = (a_wide >= 32'(NUM_ELEMENTS)) ? MAX_IDX : a_wide;
  assign b_clamp  = (b_wide >= 32'(NUM_ELEMENTS)) ? MAX_IDX : b_wide;
  assign a_idx_in = a_clamp[IDX_W-1:0];
  assign b_idx_in = b_clamp[IDX_W-1:0];

  assign sum = size + c_rdata;

  always_comb begin
    p_we    = cmd.clr_write | cmd.hop_write | cmd.merge;
    p_waddr = node;
    p_wdata = p_rdata;
    if (cmd.clr_write) begin
      p_waddr = clr_cnt;
      p_wdata = clr_cnt;
    end else if (cmd.merge) begin
      p_waddr = rb;
      p_wdata = ra;
    end

    p_re    = cmd.load_in | cmd.a_root | cmd.hop_read | cmd.hop_write;
    p_raddr = p_rdata;
    if (cmd.load_in) begin
      p_raddr = a_idx_in;
    end else if (cmd.a_root) begin
      p_raddr = b_idx;
    end

    c_we    = cmd.clr_write | cmd.merge;
    c_waddr = cmd.clr_write ? clr_cnt : ra;
    c_wdata = cmd.clr_write ? CNT_W'(1) : sum;

    c_re    = cmd.a_root | cmd.b_root;
    c_raddr = node;
  end

  always_ff @(posedge clk) begin
    if (p_we) parent_mem[p_waddr] <= p_wdata;
    if (p_re) p_rdata <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) count_mem[c_waddr] <= c_wdata;
    if (c_re) c_rdata <= count_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op    <= req_op;
      node  <= a_idx_in;
      b_idx <= b_idx_in;
    end
    if (cmd.a_root) begin
      ra   <= node;
      node <= b_idx;
    end
    if (cmd.hop_write) begin
      node <= p_rdata;
    end
    if (cmd.b_root) begin
      rb     <= node;
      same   <= (ra == node);
      joined <= 1'b0;
      size   <= c_rdata;  // count of root_a, read when it was found
    end
    if (cmd.merge) begin
      joined <= 1'b1;
      size   <= sum;
    end
  end

  assign ra_wide   = 32'(ra);
  assign rb_wide   = 32'(rb);
  assign size_wide = 32'(size);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_root_a   <= ra_wide[ELEM_W-1:0];
      rsp_root_b   <= rb_wide[ELEM_W-1:0];
      rsp_same_set <= same;
      rsp_merged   <= joined;
      rsp_set_size <= size_wide[SIZE_W-1:0];
    end
  end

  assign stat.clr_last     = (clr_cnt == LAST_IDX);
  assign stat.is_root      = (p_rdata == node);
  assign stat.merge_needed = op & (ra != node);
  assign stat.out_free     = ~rsp_valid | rsp_ready;

endmodule

FILE: sv/union_find_engine_top.sv
// ----------------------------------------------------------------------------
// union_find_engine_top
// Disjoint-set engine with path halving over NUM_ELEMENTS elements.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                        | handshake
//  req     | in  | op, elem_a, elem_b                            | valid/ready
//  rsp     | out | root_a, root_b, same_set, merged, set_size    | valid/ready
//
//  an item passes IDLE, A_CHK, B_CHK and EMIT when both elements are roots,
//  plus A_GRD or B_GRD per parent hop on either walk and MERGE for a merge;
//  each hop is one read, then one writeback with the next read in the same
//  cycle on the parent memory. after reset a clearing pass over all
//  NUM_ELEMENTS entries sets identity parents and unit counts; req.ready stays low until it ends.
//  a result waits in the output register while rsp.ready is low; the next
//  request is taken meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module union_find_engine_top #(
  parameter int NUM_ELEMENTS = uf_pkg::DEF_NUM_ELEMENTS
) (
  input logic   clk,
  input logic   rst,
  uf_req_if.sink   req,
  uf_rsp_if.source rsp
);
  import uf_pkg::*;

  uf_cmd_t  cmd;
  uf_stat_t stat;

  uf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  uf_dp #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_op       (req.op),
    .req_elem_a   (req.elem_a),
    .req_elem_b   (req.elem_b),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_root_a   (rsp.root_a),
    .rsp_root_b   (rsp.root_b),
    .rsp_same_set (rsp.same_set),
    .rsp_merged   (rsp.merged),
    .rsp_set_size (rsp.set_size)
  );

endmodule

FILE: dv/tb_union_find_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_union_find_engine_top
// Self-checking bench for the union-find engine. A clocked driver feeds
// query and merge requests from a backlog. Each accepted request is run
// through a local disjoint-set model with path halving. A clocked monitor
// compares every result, field by field, with the oldest predicted one.
// Both sides idle at random, except for one stretch with no idling.
// ----------------------------------------------------------------------------
module tb_union_find_engine_top;
  import uf_pkg::*;

  localparam int NUM_ELEMS   = DEF_NUM_ELEMENTS;
  localparam int RAND_ITEMS  = 600;
  localparam int POOL_HI     = 127;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_LO    = 300;
  localparam int QUIET_HI    = 420;

  typedef struct {
    logic              op;
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;
  } uf_req_t;

  typedef struct {
    logic [ELEM_W-1:0] root_a;
    logic [ELEM_W-1:0] root_b;
    logic              same_set;
    logic              merged;
    logic [SIZE_W-1:0] set_size;
  } uf_rsp_t;

  logic clk;
  logic rst;

  uf_req_if req_ch ();
  uf_rsp_if rsp_ch ();

  union_find_engine_top #(.NUM_ELEMENTS(NUM_ELEMS)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // local disjoint-set copy
  logic [ELEM_W-1:0] link_tbl [NUM_ELEMS];
  int                size_tbl [NUM_ELEMS];

  uf_req_t pending_req [$];
  uf_rsp_t awaited_rsp [$];

  int total_reqs   = 0;
  int accepted_cnt = 0;
  int result_cnt   = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int join_cnt     = 0;
  int longest_walk = 0;
  int largest_set  = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_elem(logic [ELEM_W-1:0] v);
    if (int'(v) >= NUM_ELEMS) return NUM_ELEMS - 1;
    return int'(v);
  endfunction

  // path halving: each visited node is relinked to its grandparent
  function automatic int halve_to_root(int node);
    int hops;
    int grand;
    hops = 0;
    while (int'(link_tbl[node]) != node) begin
      grand = int'(link_tbl[link_tbl[node]]);
      link_tbl[node] = grand[ELEM_W-1:0];
      node = grand;
      hops++;
    end
    if (hops > longest_walk) longest_walk = hops;
    return node;
  endfunction

  function automatic uf_rsp_t dsu_apply(logic op, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
    int      ra;
    int      rb;
    uf_rsp_t r;
    ra = halve_to_root(clamp_elem(a));
    rb = halve_to_root(clamp_elem(b));
    r.same_set = (ra == rb);
    r.merged   = op && (ra != rb);
    if (r.merged) begin
      size_tbl[ra] += size_tbl[rb];
      link_tbl[rb] = ra[ELEM_W-1:0];
      join_cnt++;
    end
    if (size_tbl[ra] > largest_set) largest_set = size_tbl[ra];
    r.root_a   = ra[ELEM_W-1:0];
    r.root_b   = rb[ELEM_W-1:0];
    r.set_size = size_tbl[ra][SIZE_W-1:0];
    return r;
  endfunction

  function automatic bit roll_idle(int n);
    if (n >= QUIET_LO && n < QUIET_HI) return 1'b0;
    return ($urandom_range(0, 99) < 36);
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch on result %0d: %s", $time, result_cnt, what);
    err_cnt++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic queue_req(logic op, int a, int b);
    uf_req_t it;
    it.op     = op;
    it.elem_a = a[ELEM_W-1:0];
    it.elem_b = b[ELEM_W-1:0];
    pending_req.insert(pending_req.size(), it);
    total_reqs++;
  endtask

  // driver: next request goes out when the bus is empty or the current one transfers
  always @(posedge clk) begin
    uf_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_rsp.insert(awaited_rsp.size(),
                           dsu_apply(req_ch.op, req_ch.elem_a, req_ch.elem_b));
        accepted_cnt++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_req.size() != 0 && !roll_idle(accepted_cnt)) begin
          nxt = pending_req.pop_front();
          req_ch.valid  <= 1'b1;
          req_ch.op     <= nxt.op;
          req_ch.elem_a <= nxt.elem_a;
          req_ch.elem_b <= nxt.elem_b;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    uf_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = awaited_rsp.pop_front();
          check_field("root_a", int'(rsp_ch.root_a), int'(want.root_a));
          check_field("root_b", int'(rsp_ch.root_b), int'(want.root_b));
          check_field("same_set", int'(rsp_ch.same_set), int'(want.same_set));
          check_field("merged", int'(rsp_ch.merged), int'(want.merged));
          check_field("set_size", int'(rsp_ch.set_size), int'(want.set_size));
        end
        result_cnt++;
      end
      rsp_ch.ready <= !roll_idle(result_cnt);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_cnt, result_cnt, total_reqs);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int rand_cnt;
    int kind;
    int prev;
    int nxt;
    int len;

    clk          = 1'b0;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = 1'b0;
    req_ch.elem_a = '0;
    req_ch.elem_b = '0;
    rsp_ch.ready = 1'b0;

    for (int i = 0; i < NUM_ELEMS; i++) begin
      link_tbl[i] = i[ELEM_W-1:0];
      size_tbl[i] = 1;
    end

    // directed: index extremes, both ops, merge within one set, deep chain
    queue_req(1'b0, 0, 0);
    queue_req(1'b0, 1023, 1023);
    queue_req(1'b0, 0, 1023);
    queue_req(1'b1, 0, 1023);
    queue_req(1'b1, 1023, 0);
    queue_req(1'b1, 5, 5);
    queue_req(1'b0, 682, 341);
    queue_req(1'b1, 682, 341);
    for (int k = 10; k < 20; k++) queue_req(1'b1, k + 1, k);
    queue_req(1'b0, 10, 20);
    queue_req(1'b0, 10, 20);
    queue_req(1'b1, 1023, 10);
    queue_req(1'b0, 0, 20);

    // random: mostly chained merges in a small pool to build deep trees
    rand_cnt = 0;
    while (rand_cnt < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        prev = $urandom_range(0, POOL_HI);
        len  = $urandom_range(2, 8);
        for (int j = 0; j < len; j++) begin
          nxt = $urandom_range(0, POOL_HI);
          queue_req(1'b1, nxt, prev);
          prev = nxt;
          rand_cnt++;
        end
      end else if (kind < 70) begin
        queue_req(1'($urandom_range(0, 1)), $urandom_range(0, POOL_HI),
                  $urandom_range(0, POOL_HI));
        rand_cnt++;
      end else if (kind < 85) begin
        queue_req(1'b0, $urandom_range(0, POOL_HI), $urandom_range(0, POOL_HI));
        rand_cnt++;
      end else begin
        queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                  $urandom_range(0, 1023));
        rand_cnt++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (accepted_cnt != total_reqs || awaited_rsp.size() != 0);
    repeat (64) @(posedge clk);

    $display("ran %0d requests, %0d merges joined sets, largest set %0d",
             total_reqs, join_cnt, largest_set);
    $display("longest parent walk %0d hops, %0d mismatches", longest_walk, err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/uf_pkg.sv
sv/uf_if.sv
sv/uf_ctrl.sv
sv/uf_dp.sv
sv/union_find_engine_top.sv
dv/tb_union_find_engine_top.sv
